[hw/rtl/mrte_pkg.sv]
`default_nettype none

package mrte_pkg;

    localparam int REG_COUNT  = 32;
    localparam int IDX_W      = 5;
    localparam int REG_ADDR_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int DATA_W     = 32;

    // command codes
    localparam logic [1:0] CMD_EXEC  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // R-type function codes
    localparam logic [5:0] FN_SLL  = 6'd0;
    localparam logic [5:0] FN_SRL  = 6'd2;
    localparam logic [5:0] FN_SRA  = 6'd3;
    localparam logic [5:0] FN_JR   = 6'd8;
    localparam logic [5:0] FN_ADD  = 6'd32;
    localparam logic [5:0] FN_ADDU = 6'd33;
    localparam logic [5:0] FN_SUB  = 6'd34;
    localparam logic [5:0] FN_SUBU = 6'd35;
    localparam logic [5:0] FN_AND  = 6'd36;
    localparam logic [5:0] FN_OR   = 6'd37;
    localparam logic [5:0] FN_NOR  = 6'd39;
    localparam logic [5:0] FN_SLT  = 6'd42;
    localparam logic [5:0] FN_SLTU = 6'd43;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              wrote;
        logic              overflow;
        logic              jump;
        logic [DATA_W-1:0] jump_target;
        logic              unknown_op;
    } rsp_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] data;
    } rf_wr_t;

    function automatic logic idx_in_range(input logic [IDX_W-1:0] idx);
        return {1'b0, idx} < (IDX_W + 1)'(REG_COUNT);
    endfunction

endpackage

`default_nettype wire

[hw/rtl/mrte_if.sv]
`default_nettype none

interface mrte_req_if
    import mrte_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [1:0]        cmd;
    logic [5:0]        func_code;
    logic [IDX_W-1:0]  src_a;
    logic [IDX_W-1:0]  src_b;
    logic [IDX_W-1:0]  dest;
    logic [4:0]        shift_amount;
    logic [DATA_W-1:0] write_value;

    modport source (
        output valid, cmd, func_code, src_a, src_b, dest, shift_amount, write_value,
        input  ready
    );
    modport sink (
        input  valid, cmd, func_code, src_a, src_b, dest, shift_amount, write_value,
        output ready
    );
endinterface

interface mrte_rsp_if
    import mrte_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] result;
    logic              wrote;
    logic              overflow;
    logic              jump;
    logic [DATA_W-1:0] jump_target;
    logic              unknown_op;

    modport source (
        output valid, result, wrote, overflow, jump, jump_target, unknown_op,
        input  ready
    );
    modport sink (
        input  valid, result, wrote, overflow, jump, jump_target, unknown_op,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/mrte_regfile.sv]
`default_nettype none

module mrte_regfile
    import mrte_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic [IDX_W-1:0]  ra,
    input  wire logic [IDX_W-1:0]  rb,
    input  wire rf_wr_t            wr,
    output logic      [DATA_W-1:0] rdata_a,
    output logic      [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0]    mem [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;

    logic [DATA_W-1:0] mem_a_reg;
    logic [DATA_W-1:0] mem_b_reg;
    logic [DATA_W-1:0] byp_data_reg;
    logic              byp_a_reg;
    logic              byp_b_reg;
    logic              hit_a_reg;
    logic              hit_b_reg;

    logic [REG_ADDR_W-1:0] ra_addr;
    logic [REG_ADDR_W-1:0] rb_addr;
    logic [REG_ADDR_W-1:0] wa_addr;
    logic                  wr_ok;

    assign ra_addr = ra[REG_ADDR_W-1:0];
    assign rb_addr = rb[REG_ADDR_W-1:0];
    assign wa_addr = wr.idx[REG_ADDR_W-1:0];
    assign wr_ok   = wr.en && idx_in_range(wr.idx);

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem[wa_addr] <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_ok)
        begin
            valid_reg[wa_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mem_a_reg    <= mem[ra_addr];
            mem_b_reg    <= mem[rb_addr];
            byp_data_reg <= wr.data;
        end
    end

    // write in the same cycle as the read wins over the array contents
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_a_reg <= 1'b0;
            byp_b_reg <= 1'b0;
            hit_a_reg <= 1'b0;
            hit_b_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            byp_a_reg <= wr_ok && (wr.idx == ra);
            byp_b_reg <= wr_ok && (wr.idx == rb);
            hit_a_reg <= idx_in_range(ra) && valid_reg[ra_addr];
            hit_b_reg <= idx_in_range(rb) && valid_reg[rb_addr];
        end
    end

    always_comb
    begin
        if (byp_a_reg)
            rdata_a = byp_data_reg;
        else if (hit_a_reg)
            rdata_a = mem_a_reg;
        else
            rdata_a = '0;

        if (byp_b_reg)
            rdata_b = byp_data_reg;
        else if (hit_b_reg)
            rdata_b = mem_b_reg;
        else
            rdata_b = '0;
    end

endmodule

`default_nettype wire

[hw/rtl/mrte_alu.sv]
`default_nettype none

module mrte_alu
    import mrte_pkg::*;
(
    input  wire logic [1:0]        cmd,
    input  wire logic [5:0]        func_code,
    input  wire logic [4:0]        shift_amount,
    input  wire logic [DATA_W-1:0] write_value,
    input  wire logic [IDX_W-1:0]  dest,
    input  wire logic [DATA_W-1:0] a,
    input  wire logic [DATA_W-1:0] b,
    output rsp_t                   rsp
);

    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] diff;
    logic              dest_ok;

    assign sum     = a + b;
    assign diff    = a - b;
    assign dest_ok = idx_in_range(dest);

    always_comb
    begin
        rsp = '0;
        case (cmd)
            CMD_WRITE:
            begin
                rsp.result = write_value;
                rsp.wrote  = dest_ok;
            end
            CMD_READ:
            begin
                rsp.result = a;
            end
            CMD_EXEC:
            begin
                rsp.wrote = dest_ok;
                case (func_code)
                    FN_JR:
                    begin
                        rsp.wrote       = 1'b0;
                        rsp.jump        = 1'b1;
                        rsp.jump_target = a;
                    end
                    FN_ADD:
                    begin
                        rsp.result   = sum;
                        rsp.overflow = (a[DATA_W-1] ^ sum[DATA_W-1])
                                     & (b[DATA_W-1] ^ sum[DATA_W-1]);
                    end
                    FN_ADDU: rsp.result = sum;
                    FN_SUB:
                    begin
                        rsp.result   = diff;
                        rsp.overflow = (a[DATA_W-1] ^ b[DATA_W-1])
                                     & (a[DATA_W-1] ^ diff[DATA_W-1]);
                    end
                    FN_SUBU: rsp.result = diff;
                    FN_SLL:  rsp.result = b << shift_amount;
                    FN_SRL:  rsp.result = b >> shift_amount;
                    FN_SRA:  rsp.result = DATA_W'($signed(b) >>> shift_amount);
                    FN_AND:  rsp.result = a & b;
                    FN_OR:   rsp.result = a | b;
                    FN_NOR:  rsp.result = ~(a | b);
                    FN_SLT:  rsp.result = DATA_W'($signed(a) < $signed(b));
                    FN_SLTU: rsp.result = DATA_W'(a < b);
                    default:
                    begin
                        rsp.wrote      = 1'b0;
                        rsp.unknown_op = 1'b1;
                    end
                endcase
            end
            default: rsp = '0;
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/mips_r_type_execute_core.sv]
`default_nettype none

// MIPS32 R-type execute core with a 32 x 32-bit register file (all zero after
// reset, register 0 writable). One transaction is taken per clock while rsp
// does not stall the core. The accepting edge reads both source registers
// from the synchronous register-file ports into stage 1; stage 1 then runs the
// ALU, writes the destination and loads the output register. A write-through
// bypass lets a transaction read a register written by the one just ahead of
// it, so full throughput holds for dependent instruction streams. The output
// register lets a new transaction enter while a response waits; backpressure
// on rsp stalls both stages.
module mips_r_type_execute_core
    import mrte_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    mrte_req_if.sink   req,
    mrte_rsp_if.source rsp
);

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [1:0]        s1_cmd_reg;
    logic [5:0]        s1_func_reg;
    logic [4:0]        s1_shamt_reg;
    logic [DATA_W-1:0] s1_wval_reg;
    logic [IDX_W-1:0]  s1_dest_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    rsp_t              out_reg;

    logic              accept;
    logic              advance;
    logic [DATA_W-1:0] rdata_a;
    logic [DATA_W-1:0] rdata_b;
    rsp_t              alu_rsp;
    rf_wr_t            rf_wr;

    assign advance   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || advance;
    assign accept    = req.valid && req.ready;

    assign rf_wr.en   = advance && alu_rsp.wrote;
    assign rf_wr.idx  = s1_dest_reg;
    assign rf_wr.data = alu_rsp.result;

    mrte_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .ra      (req.src_a),
        .rb      (req.src_b),
        .wr      (rf_wr),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    mrte_alu u_alu (
        .cmd          (s1_cmd_reg),
        .func_code    (s1_func_reg),
        .shift_amount (s1_shamt_reg),
        .write_value  (s1_wval_reg),
        .dest         (s1_dest_reg),
        .a            (rdata_a),
        .b            (rdata_b),
        .rsp          (alu_rsp)
    );

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg   <= req.cmd;
            s1_func_reg  <= req.func_code;
            s1_shamt_reg <= req.shift_amount;
            s1_wval_reg  <= req.write_value;
            s1_dest_reg  <= req.dest;
        end
        if (advance)
        begin
            out_reg <= alu_rsp;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.result      = out_reg.result;
    assign rsp.wrote       = out_reg.wrote;
    assign rsp.overflow    = out_reg.overflow;
    assign rsp.jump        = out_reg.jump;
    assign rsp.jump_target = out_reg.jump_target;
    assign rsp.unknown_op  = out_reg.unknown_op;

endmodule

`default_nettype wire

[bench/mips_r_type_execute_core_tb.sv]
`timescale 1ns / 1ps

module mips_r_type_execute_core_tb
    import mrte_pkg::*;
;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_INSTRS = 700;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [5:0]  fn;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  shamt;
        logic [31:0] wdata;
    } instr_t;

    logic clk;
    logic rst_n;

    mrte_req_if req_ch ();
    mrte_rsp_if rsp_ch ();

    mips_r_type_execute_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic [31:0] shadow_regs [32];
    instr_t      pending_instrs [$];
    rsp_t        expected_rsps [$];
    instr_t      in_flight;

    int issue_gap;
    bit send_idle;
    int stall_left;
    bit recv_idle;
    int error_count;
    int sent_count;
    int checked_count;
    int ovf_count;
    int jump_count;
    int unknown_count;
    int cycle_count;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // ---------------- register file shadow and ALU prediction ----------------

    function automatic logic [31:0] shadow_read(input logic [4:0] idx);
        if (int'(idx) >= REG_COUNT)
            return 32'd0;
        return shadow_regs[idx];
    endfunction

    function automatic logic shadow_write(input logic [4:0] idx, input logic [31:0] val);
        if (int'(idx) >= REG_COUNT)
            return 1'b0;
        shadow_regs[idx] = val;
        return 1'b1;
    endfunction

    function automatic rsp_t execute_model(input instr_t ins);
        rsp_t        r;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] v;
        logic        writes;
        r = '0;
        v = '0;
        writes = 1'b1;
        case (ins.cmd)
            CMD_WRITE:
            begin
                r.result = ins.wdata;
                r.wrote = shadow_write(ins.rd, ins.wdata);
            end
            CMD_READ:
                r.result = shadow_read(ins.rs);
            CMD_EXEC:
            begin
                a = shadow_read(ins.rs);
                b = shadow_read(ins.rt);
                case (ins.fn)
                    FN_JR:
                    begin
                        r.jump = 1'b1;
                        r.jump_target = a;
                        writes = 1'b0;
                    end
                    FN_ADD:
                    begin
                        v = a + b;
                        r.overflow = (a[31] == b[31]) && (v[31] != a[31]);
                    end
                    FN_ADDU: v = a + b;
                    FN_SUB:
                    begin
                        v = a - b;
                        r.overflow = (a[31] != b[31]) && (v[31] != a[31]);
                    end
                    FN_SUBU: v = a - b;
                    FN_SLL:  v = b << ins.shamt;
                    FN_SRL:  v = b >> ins.shamt;
                    FN_SRA:  v = $signed(b) >>> ins.shamt;
                    FN_AND:  v = a & b;
                    FN_OR:   v = a | b;
                    FN_NOR:  v = ~(a | b);
                    FN_SLT:  v = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                    FN_SLTU: v = (a < b) ? 32'd1 : 32'd0;
                    default:
                    begin
                        r.unknown_op = 1'b1;
                        writes = 1'b0;
                    end
                endcase
                if (writes)
                begin
                    r.result = v;
                    r.wrote = shadow_write(ins.rd, v);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ---------------- stimulus ----------------

    function automatic logic [5:0] known_fn(input int k);
        case (k)
            0:  return FN_SLL;
            1:  return FN_SRL;
            2:  return FN_SRA;
            3:  return FN_JR;
            4:  return FN_ADD;
            5:  return FN_ADDU;
            6:  return FN_SUB;
            7:  return FN_SUBU;
            8:  return FN_AND;
            9:  return FN_OR;
            10: return FN_NOR;
            11: return FN_SLT;
            default: return FN_SLTU;
        endcase
    endfunction

    // a few hot registers keep dependency chains going back to back
    function automatic logic [4:0] pick_reg();
        if ($urandom_range(0, 99) < 35)
            return 5'($urandom_range(0, 3));
        return 5'($urandom_range(0, 31));
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return 32'h8000_0000;
            3: return 32'h7fff_ffff;
            4: return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    function automatic instr_t random_instr();
        instr_t ins;
        int     sel;
        sel = $urandom_range(0, 99);
        ins.fn = 6'($urandom_range(0, 63));
        ins.rs = pick_reg();
        ins.rt = pick_reg();
        ins.rd = pick_reg();
        ins.shamt = 5'($urandom_range(0, 31));
        ins.wdata = pick_value();
        if (sel < 15)
            ins.cmd = CMD_WRITE;
        else if (sel < 22)
            ins.cmd = CMD_READ;
        else if (sel < 25)
            ins.cmd = CMD_UNUSED;
        else
        begin
            ins.cmd = CMD_EXEC;
            if ($urandom_range(0, 9) != 0)
                ins.fn = known_fn($urandom_range(0, 12));
        end
        return ins;
    endfunction

    task automatic queue_instr(input logic [1:0] cmd, input logic [5:0] fn,
                               input logic [4:0] rs, input logic [4:0] rt,
                               input logic [4:0] rd, input logic [4:0] shamt,
                               input logic [31:0] wdata);
        instr_t ins;
        ins.cmd = cmd;
        ins.fn = fn;
        ins.rs = rs;
        ins.rt = rt;
        ins.rd = rd;
        ins.shamt = shamt;
        ins.wdata = wdata;
        pending_instrs.push_back(ins);
    endtask

    // ---------------- request driver ----------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.cmd <= '0;
            req_ch.func_code <= '0;
            req_ch.src_a <= '0;
            req_ch.src_b <= '0;
            req_ch.dest <= '0;
            req_ch.shift_amount <= '0;
            req_ch.write_value <= '0;
            issue_gap = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                expected_rsps.push_back(execute_model(in_flight));
                sent_count++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (issue_gap != 0)
                begin
                    issue_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_instrs.size() != 0)
                begin
                    in_flight = pending_instrs.pop_front();
                    req_ch.valid <= 1'b1;
                    req_ch.cmd <= in_flight.cmd;
                    req_ch.func_code <= in_flight.fn;
                    req_ch.src_a <= in_flight.rs;
                    req_ch.src_b <= in_flight.rt;
                    req_ch.dest <= in_flight.rd;
                    req_ch.shift_amount <= in_flight.shamt;
                    req_ch.write_value <= in_flight.wdata;
                    issue_gap = send_idle ? $urandom_range(0, 15) : 0;
                    if ($urandom_range(0, 39) == 0)
                        send_idle = !send_idle;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // ---------------- response monitor ----------------

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $display("%0t: response with none expected, expected none, actual %h",
                             $time, rsp_ch.result);
                    error_count++;
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    check_field("result", want.result, rsp_ch.result);
                    check_field("wrote", 32'(want.wrote), 32'(rsp_ch.wrote));
                    check_field("overflow", 32'(want.overflow), 32'(rsp_ch.overflow));
                    check_field("jump", 32'(want.jump), 32'(rsp_ch.jump));
                    check_field("jump_target", want.jump_target, rsp_ch.jump_target);
                    check_field("unknown_op", 32'(want.unknown_op), 32'(rsp_ch.unknown_op));
                    checked_count++;
                    ovf_count += int'(want.overflow);
                    jump_count += int'(want.jump);
                    unknown_count += int'(want.unknown_op);
                end
                stall_left = recv_idle ? $urandom_range(0, 15) : 0;
                if ($urandom_range(0, 39) == 0)
                    recv_idle = !recv_idle;
            end
            if (stall_left != 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial
    begin
        rst_n = 1'b0;
        error_count = 0;
        sent_count = 0;
        checked_count = 0;
        ovf_count = 0;
        jump_count = 0;
        unknown_count = 0;
        cycle_count = 0;
        send_idle = 1'b1;
        recv_idle = 1'b1;
        for (int i = 0; i < 32; i++)
            shadow_regs[i] = 32'd0;

        // directed: extreme operands, every function code, corner cases
        queue_instr(CMD_WRITE, FN_SLL, 0, 0, 1, 0, 32'h7fff_ffff);
        queue_instr(CMD_WRITE, FN_SLL, 0, 0, 2, 0, 32'h0000_0001);
        queue_instr(CMD_WRITE, FN_SLL, 0, 0, 3, 0, 32'h8000_0000);
        queue_instr(CMD_WRITE, FN_SLL, 0, 0, 4, 0, 32'hffff_ffff);
        queue_instr(CMD_WRITE, 6'h3f, 31, 31, 0, 31, 32'ha5a5_a5a5);
        queue_instr(CMD_READ, FN_SLL, 0, 0, 0, 0, 32'd0);
        queue_instr(CMD_EXEC, FN_ADD, 1, 2, 5, 0, 32'd0);
        queue_instr(CMD_EXEC, FN_ADD, 3, 4, 6, 0, 32'd0);
        queue_instr(CMD_EXEC, FN_ADDU, 1, 2, 7, 0, 32'd0);
        queue_instr(CMD_EXEC, FN_SUB, 3, 2, 8, 0, 32'd0);
        queue_instr(CMD_EXEC, FN_SUB, 1, 4, 9, 0, 32'd0);
        queue_instr(CMD_EXEC, FN_SUBU, 3, 2, 10, 0, 32'd0);
        queue_instr(CMD_EXEC, FN_SLL, 0, 4, 11, 31, 32'd0);
        queue_instr(CMD_EXEC, FN_SRL, 0, 3, 12, 31, 32'd0);
        queue_instr(CMD_EXEC, FN_SRA, 0, 3, 13, 31, 32'd0);
        queue_instr(CMD_EXEC, FN_SRA, 0, 3, 14, 0, 32'd0);
        queue_instr(CMD_EXEC, FN_AND, 1, 4, 15, 0, 32'd0);
        queue_instr(CMD_EXEC, FN_OR, 3, 2, 16, 0, 32'd0);
        queue_instr(CMD_EXEC, FN_NOR, 0, 2, 31, 0, 32'd0);
        queue_instr(CMD_EXEC, FN_SLT, 3, 1, 17, 0, 32'd0);
        queue_instr(CMD_EXEC, FN_SLTU, 3, 1, 18, 0, 32'd0);
        queue_instr(CMD_EXEC, FN_JR, 3, 4, 19, 5, 32'd0);
        queue_instr(CMD_EXEC, 6'h3f, 1, 2, 20, 0, 32'd0);
        queue_instr(CMD_EXEC, 6'd1, 1, 2, 21, 0, 32'd0);
        queue_instr(CMD_UNUSED, FN_ADD, 1, 2, 22, 7, 32'hdead_beef);
        queue_instr(CMD_READ, FN_SLL, 31, 0, 0, 0, 32'd0);

        for (int i = 0; i < RANDOM_INSTRS; i++)
            pending_instrs.push_back(random_instr());

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_instrs.size() != 0 || req_ch.valid)
            @(posedge clk);
        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d transactions through the execute core, %0d responses checked.",
                 sent_count, checked_count);
        $display("Responses seen: %0d signed overflows, %0d jr, %0d unknown function codes.",
                 ovf_count, jump_count, unknown_count);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
